### rtl/ppt_pkg.sv
// Package for the planar pose transform: angle and vector formats,
// CORDIC arctangent table and operation codes. No dependencies.
package ppt_pkg;

   localparam int ANG_FRAC      = 28;
   localparam int TRIG_FRAC     = 30;
   localparam int ANGLE_BITS    = 34;
   localparam int VEC_BITS      = 34;
   localparam int TRIG_MAG_BITS = 32;
   localparam int ATAN_COUNT    = 24;

   typedef logic signed [ANGLE_BITS-1:0] angle_type;
   typedef logic signed [VEC_BITS-1:0]   vec_type;

   localparam angle_type PI_Q28      = 34'sd843314857;
   localparam angle_type HALF_PI_Q28 = 34'sd421657428;
   localparam vec_type   GAIN_Q30    = 34'sd652032874;

   localparam angle_type ATAN_Q28 [ATAN_COUNT] = '{
      34'sd210828714, 34'sd124459457, 34'sd65760959, 34'sd33381290,
      34'sd16755422,  34'sd8385879,   34'sd4193963,  34'sd2097109,
      34'sd1048571,   34'sd524287,    34'sd262144,   34'sd131072,
      34'sd65536,     34'sd32768,     34'sd16384,    34'sd8192,
      34'sd4096,      34'sd2048,      34'sd1024,     34'sd512,
      34'sd256,       34'sd128,       34'sd64,       34'sd32
   };

   typedef enum logic [1:0] {
      OP_COMPOSE,
      OP_RELATIVE,
      OP_ADD,
      OP_SUBTRACT
   } op_type;

endpackage

### rtl/planar_pose_transform.sv
// Planar pose transform top level: prep stage, CORDIC pipeline and rotation
// back end. Depends on ppt_pkg, ppt_prep, ppt_cordic_stage, ppt_rotate.
//
// Usage: the req channel carries two poses a and b in req_tdata and the
// operation code in req_tuser (compose, relative, add, subtract). The rsp
// channel returns one pose per transfer in rsp_tdata with the saturation
// flag in rsp_tuser.
// Throughput: one transfer per cycle while the output is not stalled. The
// path from req transfer to rsp_tvalid is one prep stage, one stage per
// CORDIC iteration and four back-end stages (sign fold, split products,
// rounding, final sum and clamp).
// Reset: synchronous; clears every stage valid, the pipeline comes up empty
// and rsp_tvalid is low in the cycle after reset.
// Stall: while rsp_tvalid is high and rsp_tready low, the whole pipeline
// holds, req_tready drops and no item is lost or repeated; as soon as the
// output register is empty or drained, the pipeline advances again.
module planar_pose_transform import ppt_pkg::*; #(
   parameter int POSITION_BITS = 32,
   parameter int HEADING_BITS  = 18,
   parameter int CORDIC_STEPS  = 16,
   localparam int REQ_W = ((4 * POSITION_BITS + 2 * HEADING_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((2 * POSITION_BITS + HEADING_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // a_x, a_y, a_heading, b_x, b_y, b_heading
   input  logic [1:0]       req_tuser,  // operation
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // out_x, out_y, out_heading
   output logic             rsp_tuser   // saturated
);

   localparam int P      = POSITION_BITS;
   localparam int HB     = HEADING_BITS;
   localparam int SIDE_W = 6 * P + HB + 8;

   logic signed [P-1:0]  a_x, a_y, b_x, b_y, out_x, out_y;
   logic signed [HB-1:0] a_heading, b_heading, out_heading;
   logic                 en;

   assign a_x       = req_tdata[P-1:0];
   assign a_y       = req_tdata[2*P-1:P];
   assign a_heading = req_tdata[2*P+HB-1:2*P];
   assign b_x       = req_tdata[3*P+HB-1:2*P+HB];
   assign b_y       = req_tdata[4*P+HB-1:3*P+HB];
   assign b_heading = req_tdata[4*P+2*HB-1:4*P+HB];

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic              cv    [CORDIC_STEPS+1];
   vec_type           cx    [CORDIC_STEPS+1];
   vec_type           cy    [CORDIC_STEPS+1];
   angle_type         cz    [CORDIC_STEPS+1];
   logic [SIDE_W-1:0] cside [CORDIC_STEPS+1];

   assign cx[0] = GAIN_Q30;
   assign cy[0] = '0;

   ppt_prep #(
      .POSITION_BITS(P),
      .HEADING_BITS (HB),
      .SIDE_W       (SIDE_W)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .op       (op_type'(req_tuser)),
      .a_x      (a_x),
      .a_y      (a_y),
      .a_heading(a_heading),
      .b_x      (b_x),
      .b_y      (b_y),
      .b_heading(b_heading),
      .valid_ff (cv[0]),
      .z_ff     (cz[0]),
      .side_ff  (cside[0])
   );

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      ppt_cordic_stage #(
         .IDX   (i),
         .SIDE_W(SIDE_W)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .src_valid(cv[i]),
         .src_x    (cx[i]),
         .src_y    (cy[i]),
         .src_z    (cz[i]),
         .src_side (cside[i]),
         .valid_ff (cv[i+1]),
         .x_ff     (cx[i+1]),
         .y_ff     (cy[i+1]),
         .z_ff     (cz[i+1]),
         .side_ff  (cside[i+1])
      );
   end

   ppt_rotate #(
      .POSITION_BITS(P),
      .HEADING_BITS (HB),
      .SIDE_W       (SIDE_W)
   ) u_rotate (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .src_valid     (cv[CORDIC_STEPS]),
      .src_cos       (cx[CORDIC_STEPS]),
      .src_sin       (cy[CORDIC_STEPS]),
      .src_side      (cside[CORDIC_STEPS]),
      .valid_ff      (rsp_tvalid),
      .out_x_ff      (out_x),
      .out_y_ff      (out_y),
      .out_heading_ff(out_heading),
      .saturated_ff  (rsp_tuser)
   );

   assign rsp_tdata = RSP_W'({out_heading, out_y, out_x});

   logic unused_z;
   assign unused_z = ^cz[CORDIC_STEPS];

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(cv[CORDIC_STEPS]))
      else $error("CORDIC pipeline moved during stall");

   a_valid_advances: assert property (@(posedge clock) disable iff (reset)
      (cv[0] && en) |=> cv[1])
      else $error("item lost between prep and first CORDIC stage");

endmodule

### rtl/ppt_prep.sv
// Input stage: angle reduction and folding for the CORDIC, heading wrap or
// clamp, position differences and sums. Depends on ppt_pkg.
module ppt_prep import ppt_pkg::*; #(
   parameter int POSITION_BITS = 32,
   parameter int HEADING_BITS  = 18,
   parameter int SIDE_W        = 6 * 32 + 18 + 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  op_type                          op,
   input  logic signed [POSITION_BITS-1:0] a_x,
   input  logic signed [POSITION_BITS-1:0] a_y,
   input  logic signed [HEADING_BITS-1:0]  a_heading,
   input  logic signed [POSITION_BITS-1:0] b_x,
   input  logic signed [POSITION_BITS-1:0] b_y,
   input  logic signed [HEADING_BITS-1:0]  b_heading,
   output logic                            valid_ff,
   output angle_type                       z_ff,
   output logic [SIDE_W-1:0]               side_ff
);

   localparam int SHIFT = ANG_FRAC - (HEADING_BITS - 4);
   localparam longint PI_H = (longint'(PI_Q28) + (longint'(1) << (SHIFT - 1))) >>> SHIFT;
   localparam logic signed [HEADING_BITS+1:0] PI_HW = (HEADING_BITS + 2)'(PI_H);
   localparam logic signed [HEADING_BITS:0] HMAX = (HEADING_BITS + 1)'((longint'(1) << (HEADING_BITS - 1)) - 1);
   localparam logic signed [HEADING_BITS:0] HMIN = -HMAX - 1;

   angle_type                        z_in;
   logic [SIDE_W-1:0]                side_in;
   logic                             flip;
   logic signed [HEADING_BITS:0]     hs;
   logic signed [HEADING_BITS+1:0]   hw;
   logic signed [HEADING_BITS-1:0]   hout;
   logic                             hsat;
   logic signed [POSITION_BITS:0]    sx, sy, dx, dy, u, w;

   always_comb begin
      z_in = angle_type'(b_heading);
      z_in = z_in <<< SHIFT;
      if (z_in > PI_Q28) begin
         z_in = z_in - (PI_Q28 <<< 1);
      end else if (z_in < -PI_Q28) begin
         z_in = z_in + (PI_Q28 <<< 1);
      end
      flip = 1'b0;
      if (z_in > HALF_PI_Q28) begin
         z_in = z_in - PI_Q28;
         flip = 1'b1;
      end else if (z_in < -HALF_PI_Q28) begin
         z_in = z_in + PI_Q28;
         flip = 1'b1;
      end

      if (op == OP_COMPOSE || op == OP_ADD) begin
         hs = (HEADING_BITS + 1)'(a_heading) + (HEADING_BITS + 1)'(b_heading);
      end else begin
         hs = (HEADING_BITS + 1)'(a_heading) - (HEADING_BITS + 1)'(b_heading);
      end
      hw = (HEADING_BITS + 2)'(hs);
      for (int k = 0; k < 3; k++) begin
         if (hw > PI_HW) begin
            hw = hw - (PI_HW <<< 1);
         end else if (hw < -PI_HW) begin
            hw = hw + (PI_HW <<< 1);
         end
      end

      hsat = 1'b0;
      if (op == OP_COMPOSE || op == OP_RELATIVE) begin
         hout = hw[HEADING_BITS-1:0];
      end else if (hs > HMAX) begin
         hout = HMAX[HEADING_BITS-1:0];
         hsat = 1'b1;
      end else if (hs < HMIN) begin
         hout = HMIN[HEADING_BITS-1:0];
         hsat = 1'b1;
      end else begin
         hout = hs[HEADING_BITS-1:0];
      end

      dx = (POSITION_BITS + 1)'(a_x) - (POSITION_BITS + 1)'(b_x);
      dy = (POSITION_BITS + 1)'(a_y) - (POSITION_BITS + 1)'(b_y);
      if (op == OP_ADD) begin
         sx = (POSITION_BITS + 1)'(a_x) + (POSITION_BITS + 1)'(b_x);
         sy = (POSITION_BITS + 1)'(a_y) + (POSITION_BITS + 1)'(b_y);
      end else begin
         sx = dx;
         sy = dy;
      end
      if (op == OP_COMPOSE) begin
         u = (POSITION_BITS + 1)'(a_x);
         w = (POSITION_BITS + 1)'(a_y);
      end else begin
         u = dx;
         w = dy;
      end
      side_in = {flip, hsat, hout, sy, sx, b_y, b_x, w, u, op};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z_ff    <= z_in;
         side_ff <= side_in;
      end
   end

endmodule

### rtl/ppt_cordic_stage.sv
// One rotation-mode CORDIC iteration with its pipeline register; carries
// the item's side data along. Depends on ppt_pkg.
module ppt_cordic_stage import ppt_pkg::*; #(
   parameter int IDX    = 0,
   parameter int SIDE_W = 230
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              src_valid,
   input  vec_type           src_x,
   input  vec_type           src_y,
   input  angle_type         src_z,
   input  logic [SIDE_W-1:0] src_side,
   output logic              valid_ff,
   output vec_type           x_ff,
   output vec_type           y_ff,
   output angle_type         z_ff,
   output logic [SIDE_W-1:0] side_ff
);

   vec_type   x_in, y_in, dx, dy;
   angle_type z_in;

   always_comb begin
      dx = src_y >>> IDX;
      dy = src_x >>> IDX;
      if (src_z >= 0) begin
         x_in = src_x - dx;
         y_in = src_y + dy;
         z_in = src_z - ATAN_Q28[IDX];
      end else begin
         x_in = src_x + dx;
         y_in = src_y - dy;
         z_in = src_z + ATAN_Q28[IDX];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= src_side;
      end
   end

endmodule

### rtl/ppt_rotate.sv
// Rotation back end: sign fold, split magnitude products, rounding, final
// sums and saturation, output register. Depends on ppt_pkg.
module ppt_rotate import ppt_pkg::*; #(
   parameter int POSITION_BITS = 32,
   parameter int HEADING_BITS  = 18,
   parameter int SIDE_W        = 6 * 32 + 18 + 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            src_valid,
   input  vec_type                         src_cos,
   input  vec_type                         src_sin,
   input  logic [SIDE_W-1:0]               src_side,
   output logic                            valid_ff,
   output logic signed [POSITION_BITS-1:0] out_x_ff,
   output logic signed [POSITION_BITS-1:0] out_y_ff,
   output logic signed [HEADING_BITS-1:0]  out_heading_ff,
   output logic                            saturated_ff
);

   localparam int M      = POSITION_BITS + 1;
   localparam int L      = (M + 1) / 2;
   localparam int H      = M - L;
   localparam int FW     = M + TRIG_MAG_BITS + 1;
   localparam int RW     = M + 4;
   localparam int CW     = POSITION_BITS + 7;
   localparam int META_W = 2 + 2 * POSITION_BITS + 2 * M + HEADING_BITS + 1;
   localparam logic signed [CW-1:0] PMAX =
      CW'((longint'(1) << (POSITION_BITS - 1)) - 1);
   localparam logic signed [CW-1:0] PMIN = -PMAX - 1;

   logic                            flip, hsat;
   logic signed [HEADING_BITS-1:0]  hout;
   logic signed [M-1:0]             sx, sy, u, w;
   logic signed [POSITION_BITS-1:0] bx, by;
   logic [1:0]                      op;
   logic [META_W-1:0]               meta;

   assign {flip, hsat, hout, sy, sx, by, bx, w, u, op} = src_side;
   assign meta = {op, bx, by, sx, sy, hout, hsat};

   vec_type                   c, s;
   logic [M-1:0]              mag_a [4];
   logic [TRIG_MAG_BITS-1:0]  mag_t [4];
   logic [3:0]                neg;

   logic [M-1:0]              a1_ff [4];
   logic [TRIG_MAG_BITS-1:0]  t1_ff [4];
   logic [3:0]                n1_ff, n2_ff;
   logic [META_W-1:0]         m1_ff, m2_ff, m3_ff;
   logic                      v1_ff, v2_ff, v3_ff;

   logic [L+TRIG_MAG_BITS-1:0] lo_ff [4];
   logic [H+TRIG_MAG_BITS-1:0] hi_ff [4];
   logic signed [RW-1:0]       p_in  [4];
   logic signed [RW-1:0]       p_ff  [4];

   always_comb begin
      c = flip ? -src_cos : src_cos;
      s = flip ? -src_sin : src_sin;
      mag_a[0] = u[M-1] ? M'(-u) : M'(u);
      mag_a[1] = w[M-1] ? M'(-w) : M'(w);
      mag_a[2] = mag_a[0];
      mag_a[3] = mag_a[1];
      mag_t[0] = c[VEC_BITS-1] ? TRIG_MAG_BITS'(-c) : TRIG_MAG_BITS'(c);
      mag_t[1] = s[VEC_BITS-1] ? TRIG_MAG_BITS'(-s) : TRIG_MAG_BITS'(s);
      mag_t[2] = mag_t[1];
      mag_t[3] = mag_t[0];
      neg[0] = u[M-1] ^ c[VEC_BITS-1];
      neg[1] = w[M-1] ^ s[VEC_BITS-1];
      neg[2] = u[M-1] ^ s[VEC_BITS-1];
      neg[3] = w[M-1] ^ c[VEC_BITS-1];
   end

   always_comb begin
      logic [FW-1:0] full;
      logic [RW-1:0] mag;
      for (int k = 0; k < 4; k++) begin
         full = (FW'(hi_ff[k]) << L) + FW'(lo_ff[k]) + (FW'(1) << (TRIG_FRAC - 1));
         mag  = RW'(full[FW-1:TRIG_FRAC]);
         p_in[k] = n2_ff[k] ? -signed'(mag) : signed'(mag);
      end
   end

   logic signed [CW-1:0]            rx, ry;
   logic signed [POSITION_BITS-1:0] out_x_in, out_y_in, m_bx, m_by;
   logic signed [M-1:0]             m_sx, m_sy;
   logic signed [HEADING_BITS-1:0]  m_hout;
   logic                            m_hsat, sat_in;
   logic [1:0]                      m_op;

   assign {m_op, m_bx, m_by, m_sx, m_sy, m_hout, m_hsat} = m3_ff;

   always_comb begin
      unique case (op_type'(m_op))
         OP_COMPOSE: begin
            rx = CW'(m_bx) + CW'(p_ff[0]) - CW'(p_ff[1]);
            ry = CW'(m_by) + CW'(p_ff[2]) + CW'(p_ff[3]);
         end
         OP_RELATIVE: begin
            rx = CW'(p_ff[0]) + CW'(p_ff[1]);
            ry = CW'(p_ff[3]) - CW'(p_ff[2]);
         end
         default: begin
            rx = CW'(m_sx);
            ry = CW'(m_sy);
         end
      endcase
      sat_in = m_hsat;
      if (rx > PMAX) begin
         out_x_in = PMAX[POSITION_BITS-1:0];
         sat_in   = 1'b1;
      end else if (rx < PMIN) begin
         out_x_in = PMIN[POSITION_BITS-1:0];
         sat_in   = 1'b1;
      end else begin
         out_x_in = rx[POSITION_BITS-1:0];
      end
      if (ry > PMAX) begin
         out_y_in = PMAX[POSITION_BITS-1:0];
         sat_in   = 1'b1;
      end else if (ry < PMIN) begin
         out_y_in = PMIN[POSITION_BITS-1:0];
         sat_in   = 1'b1;
      end else begin
         out_y_in = ry[POSITION_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff    <= src_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            a1_ff[k] <= mag_a[k];
            t1_ff[k] <= mag_t[k];
            lo_ff[k] <= (L + TRIG_MAG_BITS)'(a1_ff[k][L-1:0]) *
                        (L + TRIG_MAG_BITS)'(t1_ff[k]);
            hi_ff[k] <= (H + TRIG_MAG_BITS)'(a1_ff[k][M-1:L]) *
                        (H + TRIG_MAG_BITS)'(t1_ff[k]);
            p_ff[k]  <= p_in[k];
         end
         n1_ff          <= neg;
         n2_ff          <= n1_ff;
         m1_ff          <= meta;
         m2_ff          <= m1_ff;
         m3_ff          <= m2_ff;
         out_x_ff       <= out_x_in;
         out_y_ff       <= out_y_in;
         out_heading_ff <= m_hout;
         saturated_ff   <= sat_in;
      end
   end

endmodule
